### hdl/per_user_token_bucket_marker_top_assert.svh
// Assertion macros for the per-user token bucket marker.
// Included by per_user_token_bucket_marker_top; expects clk and rst_n in scope.
`ifndef PER_USER_TOKEN_BUCKET_MARKER_TOP_ASSERT_SVH
`define PER_USER_TOKEN_BUCKET_MARKER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PUTBM_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PUTBM_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### hdl/putbm_pkg.sv
// Shared types and constants for the per-user token bucket marker.
// No dependencies.
package putbm_pkg;

    localparam int USERS_DEFAULT = 64;

    localparam int ACTION_W   = 2;
    localparam int USER_W     = 6;
    localparam int AMOUNT_W   = 32;
    localparam int VERDICT_W  = 3;
    localparam int CAP_W      = 40;
    localparam int CFG_IDX_W  = 1;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_REQUEST   = 2'd0,
        ACT_REFILL    = 2'd1,
        ACT_IDLE_TICK = 2'd2,
        ACT_LOAD      = 2'd3
    } action_t;

    typedef enum logic [VERDICT_W-1:0] {
        V_GREEN   = 3'd0,
        V_YELLOW  = 3'd1,
        V_ORANGE  = 3'd2,
        V_RED     = 3'd3,
        V_UNKNOWN = 3'd4,
        V_ACK     = 3'd5
    } verdict_t;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_ENABLE    = 1'd1;

    // One user entry as held in the state memory.
    typedef struct packed {
        logic                valid;
        logic                active;
        logic [AMOUNT_W-1:0] limit;
        logic [AMOUNT_W-1:0] excess;
        logic [AMOUNT_W-1:0] commit;
    } entry_t;

endpackage

### hdl/per_user_token_bucket_marker_top.sv
// Per-user committed/excess token bucket marker with a shared idle bucket.
// Depends on putbm_pkg and per_user_token_bucket_marker_top_assert.svh.

// One item is in flight at a time. A request or a limit load reads the user
// entry from the state memory in its accept cycle; in ST_EXEC it then
// modifies the entry, writes it back and loads the result register. A refill
// or idle tick walks the whole memory one entry per cycle in ST_SWEEP and then
// finishes in ST_RESP. After reset a clearing pass zeroes the memory; no word
// is accepted during it, while configuration writes are taken at any time. A
// finished result waits in the output register, and an item stalls in its
// last cycle only while that register is still full and not being taken.
module per_user_token_bucket_marker_top #(
    parameter int USERS = putbm_pkg::USERS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // slave side: tuser = action[1:0]; tdata = user[5:0], amount[37:6], zeros
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [putbm_pkg::ACTION_W-1:0]   s_tuser,
    input  logic [putbm_pkg::S_TDATA_W-1:0]  s_tdata,
    // master side: tdata = verdict[2:0], zeros
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [putbm_pkg::M_TDATA_W-1:0]  m_tdata,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [putbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [putbm_pkg::CAP_W-1:0]      cfg_data
);
    import putbm_pkg::*;

    localparam int IDX_W   = (USERS > 1) ? $clog2(USERS) : 1;
    localparam int CMP_W   = (USER_W > IDX_W + 1) ? USER_W : IDX_W + 1;
    localparam int SUM_W   = AMOUNT_W + IDX_W + 1;
    localparam int TOT_W   = (SUM_W > CAP_W) ? SUM_W : CAP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(USERS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_RESP
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      ptr_reg, ptr_next;
    logic                  out_valid_reg, out_valid_next;
    verdict_t              out_verdict_reg, out_verdict_next;
    logic [CAP_W-1:0]      idle_level_reg, idle_level_next;
    logic [CAP_W-1:0]      idle_limit_reg, idle_limit_next;
    logic [CAP_W-1:0]      total_capacity_reg;
    logic                  idle_enable_reg;

    action_t               act_reg, act_next;
    logic [USER_W-1:0]     user_reg, user_next;
    logic [AMOUNT_W-1:0]   amount_reg, amount_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;

    entry_t                mem [USERS];
    entry_t                rd_word_reg;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    entry_t                wr_word;

    logic                  accept;
    logic                  slot_free;
    logic                  in_range;
    verdict_t              req_verdict;
    entry_t                req_word;
    logic [CAP_W-1:0]      req_idle_level;
    entry_t                sweep_word;
    logic [AMOUNT_W:0]     carry;
    logic [TOT_W-1:0]      total_ext;
    logic [TOT_W-1:0]      sum_ext;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = M_TDATA_W'(out_verdict_reg);
    assign in_range  = (CMP_W'(user_reg) < CMP_W'(USERS));
    assign total_ext = TOT_W'(total_capacity_reg);
    assign sum_ext   = TOT_W'(sum_reg);

    // Request: committed first, then excess, then the shared idle bucket.
    always_comb
    begin
        req_word       = rd_word_reg;
        req_idle_level = idle_level_reg;
        if (!in_range || !rd_word_reg.valid)
        begin
            req_verdict = V_UNKNOWN;
        end
        else
        begin
            if (rd_word_reg.commit >= amount_reg)
            begin
                req_word.commit = rd_word_reg.commit - amount_reg;
                req_verdict     = V_GREEN;
            end
            else if (rd_word_reg.excess >= amount_reg)
            begin
                req_word.excess = rd_word_reg.excess - amount_reg;
                req_verdict     = V_YELLOW;
            end
            else if (idle_enable_reg && (idle_level_reg >= CAP_W'(amount_reg)))
            begin
                req_idle_level = idle_level_reg - CAP_W'(amount_reg);
                req_verdict    = V_ORANGE;
            end
            else
            begin
                req_verdict = V_RED;
            end
            req_word.active = 1'b1;
        end
    end

    // Per-entry update during a tick sweep.
    always_comb
    begin
        sweep_word = rd_word_reg;
        carry      = {1'b0, rd_word_reg.commit} + {1'b0, rd_word_reg.excess};
        sum_next   = sum_reg;
        case (act_reg)
            ACT_REFILL:
            begin
                if (rd_word_reg.valid)
                begin
                    sweep_word.commit = rd_word_reg.limit;
                    sweep_word.excess = (carry < {1'b0, rd_word_reg.limit}) ?
                                        carry[AMOUNT_W-1:0] : rd_word_reg.limit;
                end
            end
            ACT_IDLE_TICK:
            begin
                if (rd_word_reg.valid && rd_word_reg.active)
                begin
                    sum_next = sum_reg + SUM_W'(rd_word_reg.limit);
                end
                sweep_word.active = 1'b0;
            end
            default:
            begin
                sweep_word = rd_word_reg;
            end
        endcase
        // hold the total while the tick result waits
        if (state_reg == ST_RESP)
        begin
            sum_next = sum_reg;
        end
        else if (state_reg != ST_SWEEP)
        begin
            sum_next = '0;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        ptr_next         = ptr_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_verdict_next = out_verdict_reg;
        idle_level_next  = idle_level_reg;
        idle_limit_next  = idle_limit_reg;
        act_next         = act_reg;
        user_next        = user_reg;
        amount_next      = amount_reg;
        rd_en            = 1'b0;
        rd_addr          = IDX_W'(user_reg);
        wr_en            = 1'b0;
        wr_addr          = IDX_W'(user_reg);
        wr_word          = req_word;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                wr_word = '0;
                if (ptr_reg == LAST_IDX)
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next    = action_t'(s_tuser);
                    user_next   = s_tdata[USER_W-1:0];
                    amount_next = s_tdata[USER_W +: AMOUNT_W];
                    rd_en       = 1'b1;
                    ptr_next    = '0;
                    if (action_t'(s_tuser) == ACT_REFILL ||
                        action_t'(s_tuser) == ACT_IDLE_TICK)
                    begin
                        rd_addr    = '0;
                        state_next = ST_SWEEP;
                    end
                    else
                    begin
                        rd_addr    = IDX_W'(s_tdata[USER_W-1:0]);
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                // hold until the result register can take the verdict
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (act_reg == ACT_LOAD)
                    begin
                        if (in_range)
                        begin
                            wr_en            = 1'b1;
                            wr_word.valid    = 1'b1;
                            wr_word.active   = 1'b0;
                            wr_word.limit    = amount_reg;
                            wr_word.excess   = amount_reg;
                            wr_word.commit   = amount_reg;
                            out_verdict_next = V_ACK;
                        end
                        else
                        begin
                            out_verdict_next = V_UNKNOWN;
                        end
                    end
                    else
                    begin
                        wr_en            = (req_verdict != V_UNKNOWN);
                        idle_level_next  = req_idle_level;
                        out_verdict_next = req_verdict;
                    end
                end
            end
            ST_SWEEP:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg;
                wr_word = sweep_word;
                if (ptr_reg == LAST_IDX)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg + IDX_W'(1);
                    ptr_next = ptr_reg + IDX_W'(1);
                end
            end
            ST_RESP:
            begin
                // idempotent while stalled unless the configuration changes: other inputs to these updates hold
                if (act_reg == ACT_IDLE_TICK)
                begin
                    idle_limit_next = (total_ext > sum_ext) ?
                                      CAP_W'(total_ext - sum_ext) : '0;
                end
                else if (idle_enable_reg)
                begin
                    idle_level_next = idle_limit_reg;
                end
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    out_verdict_next = V_ACK;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            ptr_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_verdict_reg <= V_ACK;
            idle_level_reg  <= '0;
            idle_limit_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            ptr_reg         <= ptr_next;
            out_valid_reg   <= out_valid_next;
            out_verdict_reg <= out_verdict_next;
            idle_level_reg  <= idle_level_next;
            idle_limit_reg  <= idle_limit_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_capacity_reg <= '0;
            idle_enable_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TOTAL_CAPACITY: total_capacity_reg <= cfg_data;
                CFG_IDLE_ENABLE:    idle_enable_reg    <= cfg_data[0];
                default:            idle_enable_reg    <= idle_enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        user_reg   <= user_next;
        amount_reg <= amount_next;
        sum_reg    <= sum_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_word;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

`include "per_user_token_bucket_marker_top_assert.svh"

    `PUTBM_ASSERT_NEXT(a_one_in_flight, accept, !s_tready, "word accepted while busy")
    `PUTBM_ASSERT_NEXT(a_orange_draws_idle,
        state_reg == ST_EXEC && slot_free && act_reg == ACT_REQUEST && req_verdict == V_ORANGE,
        idle_level_reg < $past(idle_level_reg), "orange verdict did not draw idle bucket")
    `PUTBM_ASSERT_NOW(a_result_source, $rose(out_valid_reg),
        $past(state_reg) == ST_EXEC || $past(state_reg) == ST_RESP,
        "result loaded outside a finishing state")

endmodule
